>>> sv/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants for the ray/box slab intersection pipeline
// Axis and divider-lane counts used across the datapath.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // three spatial axes, two slab bounds per axis
  localparam int unsigned NumAxes = 3;
  localparam int unsigned NumDiv  = 2 * NumAxes;

endpackage

>>> sv/ray_box_slab_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: pipelined ray versus axis-aligned box slab test
// Six bit-serial dividers in pipeline form, interval merge, hit point product.
// ----------------------------------------------------------------------------
// Usage:
//   A request (ray origin, direction, box corners, all signed fixed point) is
//   taken at each rising edge with start_i high and busy_o low. busy_o is tied
//   low: the pipeline takes a new request in every cycle.
//   Each request yields one result, presented for exactly one cycle with
//   done_o high: hit_o, the hit point hit_x/y/z_o and the entry parameter
//   t_enter_o (all zero on a miss).
//   A request passes the stage A register, the slab divisions (one quotient
//   bit per pipeline stage, six restoring dividers side by side), stages B,
//   C, D, P1, P2 and the output register. Throughput is one request per cycle.
//   Reset clears the valid bits of every stage; payload registers are not
//   reset. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection
  import rbsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o,
  output logic signed [COORD_WIDTH-1:0] t_enter_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned QW = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned H  = W / 2;
  localparam int unsigned LH = W - H;

  localparam logic [W-1:0]  SGN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] SGN_Q = QW'(SGN);

  typedef logic [NumAxes-1:0][W-1:0] vec_t;

  // side data travelling alongside the dividers
  typedef struct packed {
    vec_t                  o;
    vec_t                  d;
    vec_t                  dm;
    logic [NumDiv-1:0]     tneg;
    logic [NumAxes-1:0]    par;
    logic                  pmiss;
  } div_side_t;

  // saturate a quotient magnitude to the signed coordinate range
  function automatic logic [W-1:0] sat_q(logic [QW-1:0] q, logic neg);
    logic [W-1:0] res;
    if (neg) begin
      if (q >= SGN_Q) res = SGN;
      else            res = ~q[W-1:0] + W'(1);
    end else begin
      if (q >= SGN_Q) res = ~SGN;
      else            res = q[W-1:0];
    end
    return res;
  endfunction

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Stage A: slab distances, direction magnitudes, parallel checks
  // --------------------------------------------------------------------------
  vec_t in_o, in_d, in_min, in_max;
  assign in_o   = {origin_z_i, origin_y_i, origin_x_i};
  assign in_d   = {dir_z_i, dir_y_i, dir_x_i};
  assign in_min = {box_min_z_i, box_min_y_i, box_min_x_i};
  assign in_max = {box_max_z_i, box_max_y_i, box_max_x_i};

  div_side_t         side_a;
  logic [W-1:0]      mag_a [NumDiv];

  always_comb begin
    logic [W:0]   df_lo, df_hi;
    logic         miss;
    miss = 1'b0;
    side_a.o = in_o;
    side_a.d = in_d;
    for (int k = 0; k < NumAxes; k++) begin
      df_lo = {in_min[k][W-1], in_min[k]} - {in_o[k][W-1], in_o[k]};
      df_hi = {in_max[k][W-1], in_max[k]} - {in_o[k][W-1], in_o[k]};
      mag_a[2*k]   = df_lo[W] ? (~df_lo[W-1:0] + W'(1)) : df_lo[W-1:0];
      mag_a[2*k+1] = df_hi[W] ? (~df_hi[W-1:0] + W'(1)) : df_hi[W-1:0];
      side_a.dm[k] = in_d[k][W-1] ? (~in_d[k] + W'(1)) : in_d[k];
      side_a.tneg[2*k]   = df_lo[W] ^ in_d[k][W-1];
      side_a.tneg[2*k+1] = df_hi[W] ^ in_d[k][W-1];
      side_a.par[k] = (in_d[k] == '0);
      if (side_a.par[k] &&
          (($signed(in_o[k]) < $signed(in_min[k])) ||
           ($signed(in_max[k]) < $signed(in_o[k])))) begin
        miss = 1'b1;
      end
    end
    side_a.pmiss = miss;
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: index 0 is the stage A register, one quotient bit each
  // --------------------------------------------------------------------------
  logic              vld_q  [QW+1];
  div_side_t         side_q [QW+1];
  logic [QW-1:0]     num_q  [QW+1][NumDiv];
  logic [W-1:0]      rem_q  [QW+1][NumDiv];
  logic [QW-1:0]     quo_q  [QW+1][NumDiv];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_a;
    for (int j = 0; j < NumDiv; j++) begin
      num_q[0][j] <= {mag_a[j], {FRAC_BITS{1'b0}}};
      rem_q[0][j] <= '0;
      quo_q[0][j] <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [W-1:0]  rem_d [NumDiv];
    logic [NumDiv-1:0] qbit;

    // restoring step: shift in next numerator bit, subtract if it fits
    always_comb begin
      logic [W:0] rn, rs;
      for (int j = 0; j < NumDiv; j++) begin
        rn = {rem_q[s][j], num_q[s][j][QW-1]};
        rs = rn - {1'b0, side_q[s].dm[j/2]};
        qbit[j]  = (rn >= {1'b0, side_q[s].dm[j/2]});
        rem_d[j] = qbit[j] ? rs[W-1:0] : rn[W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s+1] <= side_q[s];
      for (int j = 0; j < NumDiv; j++) begin
        num_q[s+1][j] <= num_q[s][j] << 1;
        rem_q[s+1][j] <= rem_d[j];
        quo_q[s+1][j] <= {quo_q[s][j][QW-2:0], qbit[j]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: saturate quotients and order entry/exit per axis
  // --------------------------------------------------------------------------
  vec_t t1_d, t2_d;
  always_comb begin
    logic [W-1:0] ta, tb;
    for (int k = 0; k < NumAxes; k++) begin
      ta = sat_q(quo_q[QW][2*k],   side_q[QW].tneg[2*k]);
      tb = sat_q(quo_q[QW][2*k+1], side_q[QW].tneg[2*k+1]);
      if ($signed(tb) < $signed(ta)) begin
        t1_d[k] = tb;
        t2_d[k] = ta;
      end else begin
        t1_d[k] = ta;
        t2_d[k] = tb;
      end
    end
  end

  logic               b_vld_q;
  vec_t               b_t1_q, b_t2_q, b_o_q, b_d_q;
  logic [NumAxes-1:0] b_par_q;
  logic               b_pmiss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    b_t1_q    <= t1_d;
    b_t2_q    <= t2_d;
    b_o_q     <= side_q[QW].o;
    b_d_q     <= side_q[QW].d;
    b_par_q   <= side_q[QW].par;
    b_pmiss_q <= side_q[QW].pmiss;
  end

  // --------------------------------------------------------------------------
  // Stage C: latest entry and earliest exit over bounded axes
  // --------------------------------------------------------------------------
  logic [W-1:0] lo_d, hi_d;
  logic         inf_d;
  always_comb begin
    lo_d  = '0;
    hi_d  = '0;
    inf_d = 1'b1;
    for (int k = 0; k < NumAxes; k++) begin
      if (!b_par_q[k]) begin
        if (inf_d || ($signed(lo_d) < $signed(b_t1_q[k]))) lo_d = b_t1_q[k];
        if (inf_d || ($signed(b_t2_q[k]) < $signed(hi_d))) hi_d = b_t2_q[k];
        inf_d = 1'b0;
      end
    end
  end

  logic         c_vld_q, c_inf_q, c_pmiss_q;
  logic [W-1:0] c_lo_q, c_hi_q;
  vec_t         c_o_q, c_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_lo_q    <= lo_d;
    c_hi_q    <= hi_d;
    c_inf_q   <= inf_d;
    c_pmiss_q <= b_pmiss_q;
    c_o_q     <= b_o_q;
    c_d_q     <= b_d_q;
  end

  // --------------------------------------------------------------------------
  // Stage D: overlap decision and entry parameter
  // --------------------------------------------------------------------------
  logic         d_vld_q, d_hit_q;
  logic [W-1:0] d_t_q;
  vec_t         d_o_q, d_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_hit_q <= !c_pmiss_q && (c_inf_q || !($signed(c_hi_q) < $signed(c_lo_q)));
    d_t_q   <= c_inf_q ? SGN : c_lo_q;
    d_o_q   <= c_o_q;
    d_d_q   <= c_d_q;
  end

  // --------------------------------------------------------------------------
  // Stage P1: partial products of |t| * |d| per axis
  // --------------------------------------------------------------------------
  logic [W-1:0] ta_mag;
  assign ta_mag = d_t_q[W-1] ? (~d_t_q + W'(1)) : d_t_q;

  logic               p1_vld_q, p1_hit_q;
  logic [W-1:0]       p1_t_q;
  vec_t               p1_o_q;
  logic [NumAxes-1:0] p1_neg_q;
  logic [2*H-1:0]     p00_q [NumAxes];
  logic [W-1:0]       p01_q [NumAxes];
  logic [W-1:0]       p10_q [NumAxes];
  logic [2*LH-1:0]    p11_q [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [W-1:0] bm;
    p1_hit_q <= d_hit_q;
    p1_t_q   <= d_t_q;
    p1_o_q   <= d_o_q;
    for (int k = 0; k < NumAxes; k++) begin
      bm = d_d_q[k][W-1] ? (~d_d_q[k] + W'(1)) : d_d_q[k];
      p1_neg_q[k] <= d_t_q[W-1] ^ d_d_q[k][W-1];
      p00_q[k] <= ta_mag[H-1:0] * bm[H-1:0];
      p01_q[k] <= ta_mag[H-1:0] * bm[W-1:H];
      p10_q[k] <= ta_mag[W-1:H] * bm[H-1:0];
      p11_q[k] <= ta_mag[W-1:H] * bm[W-1:H];
    end
  end

  // --------------------------------------------------------------------------
  // Stage P2: sum partials, drop fraction, saturate magnitude
  // --------------------------------------------------------------------------
  logic               p2_vld_q, p2_hit_q;
  logic [W-1:0]       p2_t_q;
  vec_t               p2_o_q, p2_mag_q;
  logic [NumAxes-1:0] p2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2*W-1:0] prod, sh;
    p2_hit_q <= p1_hit_q;
    p2_t_q   <= p1_t_q;
    p2_o_q   <= p1_o_q;
    p2_neg_q <= p1_neg_q;
    for (int k = 0; k < NumAxes; k++) begin
      prod = (2*W)'(p00_q[k]) + ((2*W)'(p01_q[k]) << H) + ((2*W)'(p10_q[k]) << H)
           + ((2*W)'(p11_q[k]) << (2*H));
      sh = prod >> FRAC_BITS;
      p2_mag_q[k] <= ((sh >> W) != '0) ? {W{1'b1}} : sh[W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage P3: add origin with saturation, register result
  // --------------------------------------------------------------------------
  vec_t pt_d;
  always_comb begin
    logic [W:0] u, s;
    for (int k = 0; k < NumAxes; k++) begin
      u = {1'b0, p2_o_q[k] ^ SGN};
      if (!p2_neg_q[k]) begin
        s = u + {1'b0, p2_mag_q[k]};
        if (s[W]) s = {1'b0, {W{1'b1}}};
      end else begin
        s = u - {1'b0, p2_mag_q[k]};
        if (s[W]) s = '0;
      end
      pt_d[k] = s[W-1:0] ^ SGN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o     <= p2_hit_q;
    hit_x_o   <= p2_hit_q ? pt_d[0] : '0;
    hit_y_o   <= p2_hit_q ? pt_d[1] : '0;
    hit_z_o   <= p2_hit_q ? pt_d[2] : '0;
    t_enter_o <= p2_hit_q ? p2_t_q  : '0;
  end

endmodule
